@@ hw/rtl/rcenc_pkg.sv @@
// ----------------------------------------------------------------------------
// rcenc_pkg
// Shared constants, command/status types and controller states for the
// 32-bit carry-handling range encoder.
// ----------------------------------------------------------------------------
package rcenc_pkg;

    // Coder geometry
    localparam int          SHIFT_BITS  = 23;
    localparam int          MAX_PENDING = 32;
    localparam int          RES_MAX     = 64;
    localparam int          BUF_AW      = 6;
    localparam int          OCNT_W      = 7;
    localparam int          PEND_W      = 6;
    localparam int          UNI_W       = 22;
    localparam int          DIV_CW      = 5;

    localparam logic [31:0] BOT_VAL     = 32'd1 << SHIFT_BITS;
    localparam logic [31:0] SETTLE_LIM  = 32'hFF << SHIFT_BITS;
    localparam logic [31:0] BIG_TOTAL   = 32'd4194303;
    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(MAX_PENDING);

    // Operation codes of an input beat
    localparam logic [2:0]  FN_SYMBOL   = 3'd0;
    localparam logic [2:0]  FN_UNIFORM  = 3'd1;
    localparam logic [2:0]  FN_BYTE     = 3'd2;
    localparam logic [2:0]  FN_WORD16   = 3'd3;
    localparam logic [2:0]  FN_WORD32   = 3'd4;
    localparam logic [2:0]  FN_FLUSH    = 3'd5;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RENORM,
        CMD_PEND,
        CMD_PREP,
        CMD_DIV,
        CMD_MUL_T,
        CMD_MUL_F,
        CMD_APPLY,
        CMD_FL_HEAD,
        CMD_FL_TAIL,
        CMD_RD,
        CMD_LD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    second;
    } dp_cmd_t;

    typedef struct packed {
        logic func_ok;
        logic is_flush;
        logic rn_done;
        logic rn_emit_pend;
        logic pend_last;
        logic pending_nz;
        logic is_uni;
        logic div_done;
        logic more;
        logic out_empty;
        logic rd_last;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RENORM,
        S_PEND,
        S_PREP,
        S_DIV,
        S_MUL_T,
        S_MUL_F,
        S_APPLY,
        S_FL_HEAD,
        S_FL_PEND,
        S_FL_TAIL,
        S_RD,
        S_LD,
        S_OUT
    } state_t;

endpackage

@@ hw/rtl/range_coder_encoder_top.sv @@
// ----------------------------------------------------------------------------
// range_coder_encoder_top
// 32-bit carry-handling range encoder with a byte-stream output.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one coding operation per beat (symbol, uniform value, byte,
//   16-bit word, 32-bit word, flush). m_* returns the coded bytes that beat
//   produced, in stream order, the last one marked by m_last_of_run;
//   m_pending_overflow and m_total_bytes show the state after the beat.
//   cfg_* writes the opening held byte; cfg_ready is always high.
// Sequence:
//   One beat is worked at a time; s_ready is high only when idle. A beat is
//   accepted and decoded, then renormalized step by step until a closing check
//   finds the range wide enough; each deferred 0xFF/0x00 byte is sent in a step
//   of its own. A coding step prepares, multiplies twice and applies; a uniform
//   value also divides between preparing and multiplying (the divider produces
//   one quotient bit per cycle); a 32-bit word or a split uniform value
//   renormalizes and codes twice. Results leave a 64-entry byte buffer one byte
//   at a time, each read and loaded before it is offered on m_*.
// Reset and stalls:
//   aresetn (synchronous, active low) returns the coder to its initial
//   interval and clears counts and flags. A low m_ready holds the current
//   output beat and pauses the drain; nothing is lost.
// ----------------------------------------------------------------------------
module range_coder_encoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [15:0] s_cum_freq,
    input  logic [15:0] s_sym_freq,
    input  logic [4:0]  s_total_shift,
    input  logic [31:0] s_total_count,
    input  logic [31:0] s_data_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run,
    output logic        m_pending_overflow,
    output logic [31:0] m_total_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import rcenc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    rcenc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rcenc_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_func             (s_func),
        .s_cum_freq         (s_cum_freq),
        .s_sym_freq         (s_sym_freq),
        .s_total_shift      (s_total_shift),
        .s_total_count      (s_total_count),
        .s_data_value       (s_data_value),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .m_out_byte         (m_out_byte),
        .m_last_of_run      (m_last_of_run),
        .m_pending_overflow (m_pending_overflow),
        .m_total_bytes      (m_total_bytes)
    );

endmodule

@@ hw/rtl/rcenc_ram.sv @@
// ----------------------------------------------------------------------------
// rcenc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/rcenc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcenc_ctrl
// Sequencer of the range encoder: walks renormalization, coding steps,
// flush and the drain of the byte buffer, driving the datapath by command.
// ----------------------------------------------------------------------------
module rcenc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  rcenc_pkg::dp_status_t status,
    output rcenc_pkg::dp_cmd_t    cmd
);
    import rcenc_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    // State and second-half flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state
    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                second_next = 1'b0;
                state_next  = status.func_ok ? S_RENORM : S_IDLE;
            end
            S_RENORM: begin
                if (status.rn_done) begin
                    state_next = status.is_flush ? S_FL_HEAD : S_PREP;
                end else if (status.rn_emit_pend) begin
                    state_next = S_PEND;
                end
            end
            S_PEND: begin
                if (status.pend_last) begin
                    state_next = S_RENORM;
                end
            end
            S_PREP:  state_next = status.is_uni ? S_DIV : S_MUL_T;
            S_DIV: begin
                if (status.div_done) begin
                    state_next = S_MUL_T;
                end
            end
            S_MUL_T: state_next = S_MUL_F;
            S_MUL_F: state_next = S_APPLY;
            S_APPLY: begin
                if (status.more) begin
                    second_next = 1'b1;
                    state_next  = S_RENORM;
                end else begin
                    state_next = status.out_empty ? S_IDLE : S_RD;
                end
            end
            S_FL_HEAD: state_next = status.pending_nz ? S_FL_PEND : S_FL_TAIL;
            S_FL_PEND: begin
                if (status.pend_last) begin
                    state_next = S_FL_TAIL;
                end
            end
            S_FL_TAIL: state_next = S_RD;
            S_RD:      state_next = S_LD;
            S_LD:      state_next = S_OUT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = status.rd_last ? S_IDLE : S_RD;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb begin
        cmd.second = second_reg;
        cmd.op     = CMD_NONE;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = CMD_LOAD;
                end
            end
            S_RENORM: begin
                if (!status.rn_done) begin
                    cmd.op = CMD_RENORM;
                end
            end
            S_PEND:    cmd.op = CMD_PEND;
            S_FL_PEND: cmd.op = CMD_PEND;
            S_PREP:    cmd.op = CMD_PREP;
            S_DIV:     cmd.op = CMD_DIV;
            S_MUL_T:   cmd.op = CMD_MUL_T;
            S_MUL_F:   cmd.op = CMD_MUL_F;
            S_APPLY:   cmd.op = CMD_APPLY;
            S_FL_HEAD: cmd.op = CMD_FL_HEAD;
            S_FL_TAIL: cmd.op = CMD_FL_TAIL;
            S_RD:      cmd.op = CMD_RD;
            S_LD:      cmd.op = CMD_LD;
            S_OUT:     m_valid = 1'b1;
            default:   cmd.op = CMD_NONE;
        endcase
    end

endmodule

@@ hw/rtl/rcenc_dp.sv @@
// ----------------------------------------------------------------------------
// rcenc_dp
// Datapath of the range encoder: interval state, renormalization, the
// coding multiplies, a radix-2 divider, flush logic and the byte buffer.
// ----------------------------------------------------------------------------
module rcenc_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rcenc_pkg::dp_cmd_t    cmd,
    output rcenc_pkg::dp_status_t status,
    input  logic [2:0]            s_func,
    input  logic [15:0]           s_cum_freq,
    input  logic [15:0]           s_sym_freq,
    input  logic [4:0]            s_total_shift,
    input  logic [31:0]           s_total_count,
    input  logic [31:0]           s_data_value,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_data,
    output logic [7:0]            m_out_byte,
    output logic                  m_last_of_run,
    output logic                  m_pending_overflow,
    output logic [31:0]           m_total_bytes
);
    import rcenc_pkg::*;

    // Latched input beat
    logic [2:0]  func_reg;
    logic [15:0] cum_reg, freq_reg;
    logic [4:0]  sh_reg;
    logic [31:0] total_reg, data_reg;

    // Coder state
    logic [31:0]       low_reg, low_next;
    logic [31:0]       range_reg, range_next;
    logic [7:0]        held_reg, held_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        first_reg, first_next;
    logic [OCNT_W-1:0] ocnt_reg, ocnt_next;
    logic [OCNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]        fill_reg, fill_next;
    logic [7:0]        tail_reg, tail_next;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;

    // Working registers
    logic [31:0]       r_reg, r_next;
    logic [UNI_W-1:0]  mulv_reg, mulv_next;
    logic [15:0]       fr_reg, fr_next;
    logic              top_reg, top_next;
    logic [UNI_W-1:0]  div_d_reg, div_d_next;
    logic [UNI_W-1:0]  rem_reg, rem_next;
    logic [31:0]       t_reg, t_next;
    logic [31:0]       rf_reg, rf_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              olast_reg, olast_next;

    // Buffer port
    logic              put_en;
    logic [7:0]        put_byte;
    logic              buf_we;
    logic              buf_re;
    logic [7:0]        buf_rdata;

    // Decode of the current coding step
    logic              big, k_sym, k_uni, k_raw8, k_hi;
    logic [15:0]       raw_v;
    logic [4:0]        sh_c;
    logic [16:0]       tot17, cum_c17, f17, room17, freq_c17;
    logic [17:0]       sum18;
    logic [31:0]       tot_nz;
    logic [UNI_W-1:0]  tot_e, val_c;
    logic [31:0]       val_raw;
    logic              sym_top, uni_top;

    // Renorm and flush helpers
    logic              rn_a, rn_b;
    logic [31:0]       cnt5;
    logic              tail_up;
    logic [9:0]        tail10;
    logic [UNI_W:0]    div_tmp;
    logic              div_ge;
    logic [53:0]       prod_t;
    logic [47:0]       prod_f;

    assign big    = total_reg > BIG_TOTAL;
    assign k_sym  = func_reg == FN_SYMBOL;
    assign k_raw8 = func_reg == FN_BYTE;
    assign k_uni  = (func_reg == FN_UNIFORM) && !(big && !cmd.second);
    assign k_hi   = (func_reg == FN_WORD32) && cmd.second;
    assign raw_v  = k_raw8 ? {8'h00, data_reg[7:0]} :
                    k_hi   ? data_reg[31:16] : data_reg[15:0];

    // Clamp symbol counts to the power-of-two total
    always_comb begin
        if (sh_reg < 5'd1) begin
            sh_c = 5'd1;
        end else if (sh_reg > 5'd16) begin
            sh_c = 5'd16;
        end else begin
            sh_c = sh_reg;
        end
        tot17    = 17'd1 << sh_c;
        cum_c17  = ({1'b0, cum_reg} >= tot17) ? tot17 - 17'd1 : {1'b0, cum_reg};
        f17      = (freq_reg == 16'd0) ? 17'd1 : {1'b0, freq_reg};
        room17   = tot17 - cum_c17;
        freq_c17 = (f17 > room17) ? room17 : f17;
        sum18    = {1'b0, cum_c17} + {1'b0, freq_c17};
        sym_top  = sum18 >= {1'b0, tot17};
    end

    // Uniform operands after the 16-bit split
    always_comb begin
        tot_nz  = (total_reg == 32'd0) ? 32'd1 : total_reg;
        tot_e   = big ? UNI_W'({16'h0000, total_reg[31:16]} + 32'd1) : tot_nz[UNI_W-1:0];
        val_raw = big ? {16'h0000, data_reg[31:16]} : data_reg;
        val_c   = (val_raw >= {{(32-UNI_W){1'b0}}, tot_e}) ? tot_e - UNI_W'(1)
                                                         : val_raw[UNI_W-1:0];
        uni_top = val_c == (tot_e - UNI_W'(1));
    end

    assign rn_a    = low_reg < SETTLE_LIM;
    assign rn_b    = low_reg[31];
    assign cnt5    = cnt_reg + 32'd5;
    assign tail_up = low_reg[SHIFT_BITS-1:0] >= cnt5[SHIFT_BITS:1];
    assign tail10  = {1'b0, low_reg[31:SHIFT_BITS]} + {9'd0, tail_up};
    assign div_tmp = {rem_reg, r_reg[31]};
    assign div_ge  = div_tmp >= {1'b0, div_d_reg};
    assign prod_t  = r_reg * mulv_reg;
    assign prod_f  = r_reg * fr_reg;

    // Next-state logic of the datapath
    always_comb begin
        low_next     = low_reg;
        range_next   = range_reg;
        held_next    = held_reg;
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        first_next   = first_reg;
        ocnt_next    = ocnt_reg;
        rd_idx_next  = rd_idx_reg;
        fill_next    = fill_reg;
        tail_next    = tail_reg;
        div_cnt_next = div_cnt_reg;
        r_next       = r_reg;
        mulv_next    = mulv_reg;
        fr_next      = fr_reg;
        top_next     = top_reg;
        div_d_next   = div_d_reg;
        rem_next     = rem_reg;
        t_next       = t_reg;
        rf_next      = rf_reg;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;
        put_en       = 1'b0;
        put_byte     = held_reg;
        buf_re       = 1'b0;
        case (cmd.op)
            CMD_LOAD: begin
                ocnt_next   = '0;
                rd_idx_next = '0;
            end
            CMD_RENORM: begin
                // Settle one byte: emit, emit with carry, defer as 0xFF, or flag overflow
                if (rn_a || rn_b) begin
                    put_en    = 1'b1;
                    put_byte  = rn_a ? held_reg : held_reg + 8'd1;
                    fill_next = rn_a ? 8'hFF : 8'h00;
                    held_next = low_reg[30:SHIFT_BITS];
                end else if (pend_reg < PEND_MAX) begin
                    pend_next = pend_reg + PEND_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
                range_next = range_reg << 8;
                low_next   = {1'b0, low_reg[SHIFT_BITS-1:0], 8'h00};
                cnt_next   = cnt_reg + 32'd1;
            end
            CMD_PEND: begin
                put_en    = 1'b1;
                put_byte  = fill_reg;
                pend_next = pend_reg - PEND_W'(1);
            end
            CMD_PREP: begin
                fr_next  = 16'd1;
                if (k_sym) begin
                    r_next    = range_reg >> sh_c;
                    mulv_next = UNI_W'(cum_c17);
                    fr_next   = freq_c17[15:0];
                    top_next  = sym_top;
                end else if (k_uni) begin
                    r_next       = range_reg;
                    rem_next     = '0;
                    div_d_next   = tot_e;
                    div_cnt_next = '0;
                    mulv_next    = val_c;
                    top_next     = uni_top;
                end else begin
                    r_next    = k_raw8 ? range_reg >> 8 : range_reg >> 16;
                    mulv_next = UNI_W'(raw_v);
                    top_next  = k_raw8 ? (raw_v[7:0] == 8'hFF) : (raw_v == 16'hFFFF);
                end
            end
            CMD_DIV: begin
                // One quotient bit per cycle, shifted into r
                rem_next     = div_ge ? UNI_W'(div_tmp - {1'b0, div_d_reg})
                                      : div_tmp[UNI_W-1:0];
                r_next       = {r_reg[30:0], div_ge};
                div_cnt_next = div_cnt_reg + DIV_CW'(1);
            end
            CMD_MUL_T: t_next  = prod_t[31:0];
            CMD_MUL_F: rf_next = prod_f[31:0];
            CMD_APPLY: begin
                low_next   = low_reg + t_reg;
                range_next = top_reg ? range_reg - t_reg : rf_reg;
            end
            CMD_FL_HEAD: begin
                cnt_next  = cnt5;
                put_en    = 1'b1;
                put_byte  = (tail10 > 10'd255) ? held_reg + 8'd1 : held_reg;
                fill_next = (tail10 > 10'd255) ? 8'h00 : 8'hFF;
                tail_next = tail10[7:0];
            end
            CMD_FL_TAIL: begin
                put_en   = 1'b1;
                put_byte = tail_reg;
            end
            CMD_RD: buf_re = 1'b1;
            CMD_LD: begin
                obyte_next  = buf_rdata;
                olast_next  = (rd_idx_reg + OCNT_W'(1)) == ocnt_reg;
                rd_idx_next = rd_idx_reg + OCNT_W'(1);
            end
            default: put_en = 1'b0;
        endcase

        // Drop bytes beyond the buffer depth
        if (buf_we) begin
            ocnt_next = ocnt_reg + OCNT_W'(1);
        end

        // Register write: the held byte follows while nothing has been coded
        if (cfg_valid) begin
            first_next = cfg_data;
            if (cnt_reg == 32'd0) begin
                held_next = cfg_data;
            end
        end
    end

    assign buf_we = put_en && !ocnt_reg[OCNT_W-1];

    // Control and coder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg     <= '0;
            range_reg   <= 32'h8000_0000;
            held_reg    <= '0;
            pend_reg    <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            first_reg   <= '0;
            ocnt_reg    <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            tail_reg    <= '0;
            div_cnt_reg <= '0;
        end else begin
            low_reg     <= low_next;
            range_reg   <= range_next;
            held_reg    <= held_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            first_reg   <= first_next;
            ocnt_reg    <= ocnt_next;
            rd_idx_reg  <= rd_idx_next;
            fill_reg    <= fill_next;
            tail_reg    <= tail_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_LOAD) begin
            func_reg  <= s_func;
            cum_reg   <= s_cum_freq;
            freq_reg  <= s_sym_freq;
            sh_reg    <= s_total_shift;
            total_reg <= s_total_count;
            data_reg  <= s_data_value;
        end
        r_reg     <= r_next;
        mulv_reg  <= mulv_next;
        fr_reg    <= fr_next;
        top_reg   <= top_next;
        div_d_reg <= div_d_next;
        rem_reg   <= rem_next;
        t_reg     <= t_next;
        rf_reg    <= rf_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    // Byte buffer for one beat's results
    rcenc_ram #(
        .WIDTH (8),
        .DEPTH (RES_MAX)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (buf_we),
        .wr_addr (ocnt_reg[BUF_AW-1:0]),
        .wr_data (put_byte),
        .rd_en   (buf_re),
        .rd_addr (rd_idx_reg[BUF_AW-1:0]),
        .rd_data (buf_rdata)
    );

    // Status to the sequencer
    always_comb begin
        status.func_ok      = func_reg <= FN_FLUSH;
        status.is_flush     = func_reg == FN_FLUSH;
        status.rn_done      = range_reg > BOT_VAL;
        status.rn_emit_pend = (rn_a || rn_b) && (pend_reg != '0);
        status.pend_last    = pend_reg == PEND_W'(1);
        status.pending_nz   = pend_reg != '0;
        status.is_uni       = k_uni;
        status.div_done     = div_cnt_reg == {DIV_CW{1'b1}};
        status.more         = !cmd.second &&
                              ((func_reg == FN_WORD32) || ((func_reg == FN_UNIFORM) && big));
        status.out_empty    = ocnt_reg == '0;
        status.rd_last      = rd_idx_reg == ocnt_reg;
    end

    assign m_out_byte         = obyte_reg;
    assign m_last_of_run      = olast_reg;
    assign m_pending_overflow = ovf_reg;
    assign m_total_bytes      = cnt_reg;

    // Pending count never passes its ceiling
    a_pend_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_MAX)
        else $error("pending count above ceiling");

    // Buffer fill never passes its depth
    a_ocnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= OCNT_W'(RES_MAX))
        else $error("buffer count above depth");

    // A coding step starts only on a normalized interval
    a_prep_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_PREP) |-> (range_reg > BOT_VAL))
        else $error("coding step on unnormalized range");

    // Buffer reads stay below the fill count
    a_rd_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_RD) |-> (rd_idx_reg < ocnt_reg))
        else $error("buffer read past fill");

    // A pending flush step always has a byte to send
    a_pend_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_PEND) |-> (pend_reg != '0))
        else $error("pending flush with empty count");

endmodule

@@ tb/range_coder_encoder_top_tb.sv @@
// ----------------------------------------------------------------------------
// range_coder_encoder_top_tb
// Self-checking bench for the range encoder. It mirrors the coder in a
// bit-accurate predictor and compares every emitted byte beat with the
// oldest predicted byte. The run covers directed edge operations, a long
// pending-0xFF run with saturation, and random traffic under three
// sender/receiver idle mixes, with first_byte rewritten between phases.
// ----------------------------------------------------------------------------
module range_coder_encoder_top_tb;
    import rcenc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  FN_SPARE6   = 3'd6;
    localparam logic [2:0]  FN_SPARE7   = 3'd7;
    localparam logic [31:0] TOP_VAL     = 32'h8000_0000;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE_CYC  = 200;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] cum_freq;
        logic [15:0] sym_freq;
        logic [4:0]  total_shift;
        logic [31:0] total_count;
        logic [31:0] data_value;
    } coder_op_t;

    typedef struct {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        pending_overflow;
        logic [31:0] total_bytes;
    } coded_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [15:0] s_cum_freq;
    logic [15:0] s_sym_freq;
    logic [4:0]  s_total_shift;
    logic [31:0] s_total_count;
    logic [31:0] s_data_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;
    logic        m_pending_overflow;
    logic [31:0] m_total_bytes;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // Predictor state
    logic [7:0]  first_byte_q;
    logic [31:0] low_q;
    logic [31:0] range_q;
    logic [7:0]  held_q;
    int unsigned pend_q;
    logic [31:0] bytes_q;
    logic        ovf_q;
    logic [7:0]  emit_buf [RES_MAX];
    int          emit_cnt;

    coded_byte_t expected_bytes [$];
    int          errors;
    int          cycles;
    int          ops_sent;
    int          bytes_checked;
    int          send_idle_pct;
    int          recv_stall_pct;

    range_coder_encoder_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_cum_freq         (s_cum_freq),
        .s_sym_freq         (s_sym_freq),
        .s_total_shift      (s_total_shift),
        .s_total_count      (s_total_count),
        .s_data_value       (s_data_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_last_of_run      (m_last_of_run),
        .m_pending_overflow (m_pending_overflow),
        .m_total_bytes      (m_total_bytes),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void put_byte(logic [7:0] b);
        if (emit_cnt < RES_MAX) begin
            emit_buf[emit_cnt] = b;
            emit_cnt++;
        end
    endfunction

    function automatic void release_pending(logic [7:0] fill);
        while (pend_q != 0) begin
            put_byte(fill);
            pend_q--;
        end
    endfunction

    // Settle top bytes of low while the range is narrow
    function automatic void renormalize();
        while (range_q <= BOT_VAL) begin
            if (low_q < SETTLE_LIM) begin
                put_byte(held_q);
                release_pending(8'hFF);
                held_q = low_q[30:23];
            end else if (low_q[31]) begin
                put_byte(held_q + 8'd1);
                release_pending(8'h00);
                held_q = low_q[30:23];
            end else if (pend_q < MAX_PENDING) begin
                pend_q++;
            end else begin
                ovf_q = 1'b1;
            end
            range_q = range_q << 8;
            low_q   = (low_q << 8) & (TOP_VAL - 1);
            bytes_q = bytes_q + 1;
        end
    endfunction

    function automatic void narrow_raw(logic [31:0] v, int bits);
        logic [31:0] r;
        logic [31:0] t;
        renormalize();
        r = range_q >> bits;
        t = r * v;
        low_q = low_q + t;
        if (((v + 32'd1) >> bits) != 0) range_q = range_q - t;
        else range_q = r;
    endfunction

    function automatic void narrow_symbol(logic [31:0] cum, logic [31:0] freq, logic [31:0] sh);
        logic [31:0] tot;
        logic [31:0] r;
        logic [31:0] t;
        if (sh < 1) sh = 1;
        if (sh > 16) sh = 16;
        tot = 32'd1 << sh;
        if (cum >= tot) cum = tot - 1;
        if (freq == 0) freq = 1;
        if (freq > tot - cum) freq = tot - cum;
        renormalize();
        r = range_q >> sh;
        t = r * cum;
        low_q = low_q + t;
        if (((cum + freq) >> sh) != 0) range_q = range_q - t;
        else range_q = r * freq;
    endfunction

    function automatic void narrow_uniform(logic [31:0] total, logic [31:0] value);
        logic [31:0] r;
        logic [31:0] t;
        if (total == 0) total = 1;
        if (total > BIG_TOTAL) begin
            narrow_raw(value & 32'hFFFF, 16);
            value = value >> 16;
            total = (total >> 16) + 1;
        end
        if (value >= total) value = total - 1;
        renormalize();
        r = range_q / total;
        t = r * value;
        low_q = low_q + t;
        if (value + 1 < total) range_q = r;
        else range_q = range_q - t;
    endfunction

    function automatic void close_stream();
        logic [31:0] tail;
        renormalize();
        bytes_q = bytes_q + 5;
        tail = low_q >> SHIFT_BITS;
        if ((low_q & (BOT_VAL - 1)) >= ((bytes_q & 32'hFF_FFFF) >> 1)) tail++;
        if (tail > 32'hFF) begin
            put_byte(held_q + 8'd1);
            release_pending(8'h00);
        end else begin
            put_byte(held_q);
            release_pending(8'hFF);
        end
        put_byte(tail[7:0]);
    endfunction

    // Predict the bytes one accepted operation produces
    function automatic void encode_op(coder_op_t op);
        coded_byte_t cb;
        emit_cnt = 0;
        case (op.func)
            FN_SYMBOL:  narrow_symbol(op.cum_freq, op.sym_freq, op.total_shift);
            FN_UNIFORM: narrow_uniform(op.total_count, op.data_value);
            FN_BYTE:    narrow_raw(op.data_value & 32'hFF, 8);
            FN_WORD16:  narrow_raw(op.data_value & 32'hFFFF, 16);
            FN_WORD32: begin
                narrow_raw(op.data_value & 32'hFFFF, 16);
                narrow_raw(op.data_value >> 16, 16);
            end
            FN_FLUSH:   close_stream();
            default: ;
        endcase
        for (int k = 0; k < emit_cnt; k++) begin
            cb.out_byte         = emit_buf[k];
            cb.last_of_run      = (k == emit_cnt - 1);
            cb.pending_overflow = ovf_q;
            cb.total_bytes      = bytes_q;
            expected_bytes.push_back(cb);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall at random and check every byte beat
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        coded_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected byte", m_out_byte, 0);
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (m_out_byte !== want.out_byte)
                    report_mismatch("out_byte", m_out_byte, want.out_byte);
                if (m_last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", m_last_of_run, want.last_of_run);
                if (m_pending_overflow !== want.pending_overflow)
                    report_mismatch("pending_overflow", m_pending_overflow,
                                    want.pending_overflow);
                if (m_total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", m_total_bytes, want.total_bytes);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Send one operation; valid stays high into the next call unless a gap falls
    task automatic send_op(coder_op_t op);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_func        <= op.func;
        s_cum_freq    <= op.cum_freq;
        s_sym_freq    <= op.sym_freq;
        s_total_shift <= op.total_shift;
        s_total_count <= op.total_count;
        s_data_value  <= op.data_value;
        do @(posedge aclk); while (!s_ready);
        encode_op(op);
        ops_sent++;
    endtask

    // Drop valid, wait for every predicted byte and let the coder go idle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_first_byte(logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        first_byte_q = v;
        if (bytes_q == 0) held_q = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic coder_op_t mk_op(logic [2:0] f, logic [15:0] c, logic [15:0] q,
                                        logic [4:0] sh, logic [31:0] tot, logic [31:0] d);
        coder_op_t op;
        op.func = f; op.cum_freq = c; op.sym_freq = q;
        op.total_shift = sh; op.total_count = tot; op.data_value = d;
        return op;
    endfunction

    // Mostly well-formed operations, some out-of-range fields, rare spare codes
    function automatic coder_op_t random_op();
        coder_op_t op;
        int pick;
        int sh;
        op.cum_freq    = $urandom();
        op.sym_freq    = $urandom();
        op.total_shift = $urandom();
        op.total_count = $urandom();
        op.data_value  = $urandom();
        pick = $urandom_range(99);
        if (pick < 30) begin
            op.func = FN_SYMBOL;
            if ($urandom_range(9) < 8) begin
                sh = $urandom_range(1, 16);
                op.total_shift = sh;
                op.cum_freq    = $urandom_range((1 << sh) - 1);
                op.sym_freq    = $urandom_range(1, (1 << sh) - op.cum_freq);
            end
        end else if (pick < 50) begin
            op.func = FN_UNIFORM;
            if ($urandom_range(1)) begin
                op.total_count = $urandom_range(1, 5000);
                op.data_value  = $urandom_range(op.total_count - 1);
            end
        end else if (pick < 62) op.func = FN_BYTE;
        else if (pick < 74) op.func = FN_WORD16;
        else if (pick < 88) op.func = FN_WORD32;
        else if (pick < 96) op.func = FN_FLUSH;
        else op.func = $urandom_range(1) ? FN_SPARE6 : FN_SPARE7;
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_edge_ops();
        send_op(mk_op(FN_SYMBOL, 16'd0, 16'd1, 5'd0, 32'd0, 32'd0));
        send_op(mk_op(FN_SYMBOL, 16'hFFFF, 16'hFFFF, 5'd31, 32'd0, 32'd0));
        send_op(mk_op(FN_SYMBOL, 16'hFFFF, 16'd0, 5'd1, 32'd0, 32'd0));
        send_op(mk_op(FN_SYMBOL, 16'd3, 16'd9, 5'd16, 32'd0, 32'd0));
        send_op(mk_op(FN_UNIFORM, 16'd0, 16'd0, 5'd0, 32'd0, 32'hFFFF_FFFF));
        send_op(mk_op(FN_UNIFORM, 16'd0, 16'd0, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_op(mk_op(FN_UNIFORM, 16'd0, 16'd0, 5'd0, BIG_TOTAL, BIG_TOTAL));
        send_op(mk_op(FN_UNIFORM, 16'd0, 16'd0, 5'd0, BIG_TOTAL + 1, 32'hFFFF_FFFF));
        send_op(mk_op(FN_UNIFORM, 16'd0, 16'd0, 5'd0, 32'd7, 32'd100));
        send_op(mk_op(FN_BYTE, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
        send_op(mk_op(FN_BYTE, 16'd0, 16'd0, 5'd0, 32'd0, 32'hFFFF_FFFF));
        send_op(mk_op(FN_WORD16, 16'd0, 16'd0, 5'd0, 32'd0, 32'h0000_FFFF));
        send_op(mk_op(FN_WORD16, 16'd0, 16'd0, 5'd0, 32'd0, 32'hFFFF_0000));
        send_op(mk_op(FN_WORD32, 16'd0, 16'd0, 5'd0, 32'd0, 32'hFFFF_FFFF));
        send_op(mk_op(FN_WORD32, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
        send_op(mk_op(FN_SPARE6, 16'hFFFF, 16'hFFFF, 5'h1F, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_op(mk_op(FN_SPARE7, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
        send_op(mk_op(FN_FLUSH, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
        send_op(mk_op(FN_BYTE, 16'd0, 16'd0, 5'd0, 32'd0, 32'h5A));
        send_op(mk_op(FN_FLUSH, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
    endtask

    // Top symbols keep low near the interval top, building a long 0xFF run
    task automatic test_pending_run();
        repeat (24) send_op(mk_op(FN_SYMBOL, 16'hFFFF, 16'd1, 5'd16, 32'd0, 32'd0));
        send_op(mk_op(FN_FLUSH, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
        repeat (3) send_op(mk_op(FN_SYMBOL, 16'hFFFF, 16'd1, 5'd16, 32'd0, 32'd0));
        send_op(mk_op(FN_FLUSH, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_op(random_op());
        send_op(mk_op(FN_FLUSH, 16'd0, 16'd0, 5'd0, 32'd0, 32'd0));
    endtask

    initial begin
        aclk = 1'b0; aresetn = 1'b0; cycles = 0; errors = 0;
        ops_sent = 0; bytes_checked = 0;
        s_valid = 1'b0; s_func = FN_SYMBOL; s_cum_freq = '0; s_sym_freq = '0;
        s_total_shift = '0; s_total_count = '0; s_data_value = '0;
        m_ready = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
        send_idle_pct = 18; recv_stall_pct = 85;
        first_byte_q = 8'd0; low_q = '0; range_q = TOP_VAL; held_q = 8'd0;
        pend_q = 0; bytes_q = '0; ovf_q = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_first_byte(8'hFF);
        test_edge_ops();
        drain();
        write_first_byte(8'h00);
        test_pending_run();
        drain();
        write_first_byte($urandom());
        test_random_traffic(18, 85, 60);
        drain();
        write_first_byte($urandom());
        test_random_traffic(85, 18, 60);
        drain();
        test_random_traffic(0, 0, 60);
        drain();

        $display("Covered %0d operations and %0d coded bytes: edge fields, a saturated",
                 ops_sent, bytes_checked);
        $display("0xFF run, and random traffic under three idle mixes.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ range_coder_encoder_top.f @@
hw/rtl/rcenc_pkg.sv
hw/rtl/rcenc_ram.sv
hw/rtl/rcenc_ctrl.sv
hw/rtl/rcenc_dp.sv
hw/rtl/range_coder_encoder_top.sv
tb/range_coder_encoder_top_tb.sv
